>>> hdl/nfba_pkg.sv
// shared types, field widths and codes for the next-fit block allocator
// no dependencies; imported by every module of the block

package nfba_pkg;

    // defaults for the top-level parameters
    localparam int DEFAULT_DEPTH    = 1024;
    localparam int DEFAULT_TAG_BITS = 16;

    // request and result field widths
    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 10;
    localparam int START_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int S_TUSER_W  = 1;

    // command codes carried in tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NO_RUN = 2'd1,
        STATUS_BAD    = 2'd2
    } status_t;

    // sequencer to match unit
    typedef struct packed {
        logic clear;
        logic step;
    } match_ctl_t;

    // match unit to sequencer
    typedef struct packed {
        logic eq;
        logic full;
    } match_sts_t;

endpackage

>>> hdl/nfba_tag_ram.sv
// owner tag store: one write port, one read port with registered read data
// depends on nfba_pkg

module nfba_tag_ram
    import nfba_pkg::*;
#(
    parameter int DEPTH    = DEFAULT_DEPTH,
    parameter int TAG_BITS = DEFAULT_TAG_BITS
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [TAG_BITS-1:0]        wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [TAG_BITS-1:0]        rd_data
);

    logic [TAG_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/nfba_match_unit.sv
// shared tag compare used by every scan, and run-length counter for the allocate scan
// depends on nfba_pkg

module nfba_match_unit
    import nfba_pkg::*;
#(
    parameter int TAG_BITS = DEFAULT_TAG_BITS,
    parameter int CNT_W    = COUNT_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  match_ctl_t          ctl,
    input  logic [TAG_BITS-1:0] tag,
    input  logic [TAG_BITS-1:0] key,
    input  logic [CNT_W-1:0]    target,
    output match_sts_t          sts
);

    logic [CNT_W-1:0] run_len_reg;
    logic [CNT_W-1:0] run_len_next;
    logic [CNT_W-1:0] run_inc;
    logic             eq;

    assign eq       = (tag == key);
    assign run_inc  = run_len_reg + CNT_W'(1);
    assign sts.eq   = eq;
    assign sts.full = eq && (run_inc == target);

    always_comb
    begin
        run_len_next = run_len_reg;
        if (ctl.clear)
        begin
            run_len_next = '0;
        end
        else if (ctl.step)
        begin
            run_len_next = eq ? run_inc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
        end
        else
        begin
            run_len_reg <= run_len_next;
        end
    end

endmodule

>>> hdl/next_fit_block_allocator.sv
// next-fit contiguous block allocator: sequencer, handshake and state
// depends on nfba_pkg, nfba_tag_ram, nfba_match_unit
//
// usage
//   slave stream takes one request per item: tuser[0] is the command
//   (0 allocate, 1 free), tdata carries count and index. master stream
//   returns exactly one result per request with start_res and status.
//   an allocate searches from the next-search pointer, wraps once to
//   entry zero, tags the first fitting run with the current owner number
//   and moves the pointer past it. a free clears the consecutive entries
//   from index that carry the owner number found at index.
// timing
//   every scan reads the tag store one entry per cycle through the single
//   read port, and the one match unit checks each entry as it returns.
//   allocate: up to two scan passes, then the run is written one entry
//   at a time; a bad count goes straight to the result.
//   free: one scan from index; a bad index goes straight to the result.
//   one request is worked on at a time; s_axis_tready is low meanwhile.
// reset
//   the store is swept to the free code, one entry per cycle, so the
//   block takes no request until the sweep is done after reset.
// stalls
//   a result waits in the output register while m_axis_tready is low;
//   the next request is still taken, but its result is held back until
//   the output register is free again.

module next_fit_block_allocator
    import nfba_pkg::*;
#(
    parameter int STORE_DEPTH = DEFAULT_DEPTH,
    parameter int TAG_BITS    = DEFAULT_TAG_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // count[10:0], index[20:11], zero[23:21]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // command[0]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // start_res[9:0], status[11:10], zero[15:12]
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = AW + 1;
    // wide enough for any count and for the depth itself
    localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;
    localparam int IW = (PW > INDEX_W) ? PW : INDEX_W;
    localparam logic [TAG_BITS-1:0] FREE_CODE = '1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_WRITE,
        ST_FREE_SCAN,
        ST_DONE
    } state_t;

    // request fields
    logic                command;
    logic [COUNT_W-1:0]  count;
    logic [INDEX_W-1:0]  index;

    assign command = s_axis_tuser[0];
    assign count   = s_axis_tdata[COUNT_W-1:0];
    assign index   = s_axis_tdata[COUNT_W+INDEX_W-1:COUNT_W];

    // sequencer state
    state_t              state_reg,       state_next;
    logic [CW-1:0]       count_reg,       count_next;
    logic [TAG_BITS-1:0] key_reg,         key_next;
    logic [AW-1:0]       next_search_reg, next_search_next;
    logic [TAG_BITS-1:0] next_owner_reg,  next_owner_next;
    logic [AW-1:0]       issue_reg,       issue_next;
    logic                issuing_reg,     issuing_next;
    logic                rd_vld_reg,      rd_vld_next;
    logic [AW-1:0]       rd_addr_reg,     rd_addr_next;
    logic                phase2_reg,      phase2_next;
    logic                first_reg,       first_next;
    logic [AW-1:0]       wr_ptr_reg,      wr_ptr_next;
    logic [CW-1:0]       wr_left_reg,     wr_left_next;
    logic [AW-1:0]       start_reg,       start_next;
    logic [START_W-1:0]  res_start_reg,   res_start_next;
    status_t             res_status_reg,  res_status_next;
    logic [START_W-1:0]  out_start_reg,   out_start_next;
    status_t             out_status_reg,  out_status_next;
    logic                out_valid_reg,   out_valid_next;

    // store and match unit hookup
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [TAG_BITS-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [TAG_BITS-1:0] ram_rd_data;
    match_ctl_t          m_ctl;
    match_sts_t          m_sts;
    logic [TAG_BITS-1:0] m_key;

    // helpers
    logic                in_fire;
    logic                issue_last;
    logic                rd_last;
    logic                wr_last;
    logic [PW-1:0]       run_start;
    logic [TAG_BITS-1:0] owner_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_status_reg, out_start_reg});

    assign issue_last = (issue_reg == AW'(STORE_DEPTH - 1));
    assign rd_last    = (rd_addr_reg == AW'(STORE_DEPTH - 1));
    assign wr_last    = (wr_ptr_reg == AW'(STORE_DEPTH - 1));
    // start of the run that ends at the returning entry
    assign run_start  = PW'(rd_addr_reg) + PW'(1) - count_reg[PW-1:0];
    assign owner_inc  = next_owner_reg + TAG_BITS'(1);

    // after its first entry the free scan compares against the owner found at
    // index; its first entry and all other scans look for the free code
    assign m_key = (state_reg == ST_FREE_SCAN && !first_reg) ? key_reg : FREE_CODE;

    nfba_tag_ram #(
        .DEPTH    (STORE_DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg),
        .rd_data (ram_rd_data)
    );

    nfba_match_unit #(
        .TAG_BITS (TAG_BITS),
        .CNT_W    (CW)
    ) u_match (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (m_ctl),
        .tag    (ram_rd_data),
        .key    (m_key),
        .target (count_reg),
        .sts    (m_sts)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        next_search_next = next_search_reg;
        next_owner_next  = next_owner_reg;
        issue_next       = issue_reg;
        issuing_next     = issuing_reg;
        rd_vld_next      = 1'b0;
        rd_addr_next     = rd_addr_reg;
        phase2_next      = phase2_reg;
        first_next       = first_reg;
        wr_ptr_next      = wr_ptr_reg;
        wr_left_next     = wr_left_reg;
        start_next       = start_reg;
        res_start_next   = res_start_reg;
        res_status_next  = res_status_reg;
        out_start_next   = out_start_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_ptr_reg;
        ram_wr_data = FREE_CODE;
        ram_rd_en   = 1'b0;
        m_ctl.clear = 1'b0;
        m_ctl.step  = 1'b0;

        // result register drains independently of the sequencer
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // read issue shared by both scans, one entry per cycle
        if ((state_reg == ST_ALLOC_SCAN || state_reg == ST_FREE_SCAN) && issuing_reg)
        begin
            ram_rd_en    = 1'b1;
            rd_vld_next  = 1'b1;
            rd_addr_next = issue_reg;
            issue_next   = issue_reg + AW'(1);
            issuing_next = !issue_last;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // clearing pass after reset
                ram_wr_en   = 1'b1;
                wr_ptr_next = wr_ptr_reg + AW'(1);
                if (wr_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                m_ctl.clear    = 1'b1;
                res_start_next = '0;
                if (in_fire)
                begin
                    count_next  = CW'(count);
                    phase2_next = 1'b0;
                    first_next  = 1'b1;
                    if (command == CMD_ALLOC)
                    begin
                        if (count == '0 || CW'(count) > CW'(STORE_DEPTH))
                        begin
                            res_status_next = STATUS_BAD;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            issue_next   = next_search_reg;
                            issuing_next = 1'b1;
                            state_next   = ST_ALLOC_SCAN;
                        end
                    end
                    else
                    begin
                        if (IW'(index) >= IW'(STORE_DEPTH))
                        begin
                            res_status_next = STATUS_BAD;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            issue_next   = AW'(index);
                            issuing_next = 1'b1;
                            state_next   = ST_FREE_SCAN;
                        end
                    end
                end
            end

            ST_ALLOC_SCAN:
            begin
                if (rd_vld_reg)
                begin
                    m_ctl.step = 1'b1;
                    priority if (m_sts.full && (!phase2_reg ||
                                                run_start[AW-1:0] < next_search_reg))
                    begin
                        // run found: stop reading, go tag it
                        start_next   = run_start[AW-1:0];
                        wr_ptr_next  = run_start[AW-1:0];
                        wr_left_next = count_reg;
                        issuing_next = 1'b0;
                        rd_vld_next  = 1'b0;
                        state_next   = ST_ALLOC_WRITE;
                    end
                    else if (m_sts.full || rd_last)
                    begin
                        // second pass only covers starts before the pointer
                        if (phase2_reg || m_sts.full || next_search_reg == '0)
                        begin
                            res_status_next = STATUS_NO_RUN;
                            issuing_next    = 1'b0;
                            rd_vld_next     = 1'b0;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            // wrap to entry zero with a fresh run count
                            m_ctl.clear  = 1'b1;
                            phase2_next  = 1'b1;
                            issue_next   = '0;
                            issuing_next = 1'b1;
                            rd_vld_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        // keep scanning
                    end
                end
            end

            ST_ALLOC_WRITE:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_data  = next_owner_reg;
                wr_ptr_next  = wr_ptr_reg + AW'(1);
                wr_left_next = wr_left_reg - CW'(1);
                if (wr_left_reg == CW'(1))
                begin
                    next_search_next = wr_last ? '0 : wr_ptr_reg + AW'(1);
                    // owner number skips the free code
                    next_owner_next  = (owner_inc == FREE_CODE) ? '0 : owner_inc;
                    res_start_next   = START_W'(start_reg);
                    res_status_next  = STATUS_OK;
                    state_next       = ST_DONE;
                end
            end

            ST_FREE_SCAN:
            begin
                res_status_next = STATUS_OK;
                if (rd_vld_reg)
                begin
                    ram_wr_addr = rd_addr_reg;
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        key_next   = ram_rd_data;
                        if (m_sts.eq)
                        begin
                            // entry already free, nothing to clear
                            issuing_next = 1'b0;
                            rd_vld_next  = 1'b0;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            ram_wr_en = 1'b1;
                            if (rd_last)
                            begin
                                issuing_next = 1'b0;
                                rd_vld_next  = 1'b0;
                                state_next   = ST_DONE;
                            end
                        end
                    end
                    else if (m_sts.eq)
                    begin
                        ram_wr_en = 1'b1;
                        if (rd_last)
                        begin
                            // clearing never wraps past the last entry
                            issuing_next = 1'b0;
                            rd_vld_next  = 1'b0;
                            state_next   = ST_DONE;
                        end
                    end
                    else
                    begin
                        issuing_next = 1'b0;
                        rd_vld_next  = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_start_next  = res_start_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            next_search_reg <= '0;
            next_owner_reg  <= '0;
            issuing_reg     <= 1'b0;
            rd_vld_reg      <= 1'b0;
            phase2_reg      <= 1'b0;
            first_reg       <= 1'b0;
            wr_ptr_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_search_reg <= next_search_next;
            next_owner_reg  <= next_owner_next;
            issuing_reg     <= issuing_next;
            rd_vld_reg      <= rd_vld_next;
            phase2_reg      <= phase2_next;
            first_reg       <= first_next;
            wr_ptr_reg      <= wr_ptr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        key_reg        <= key_next;
        issue_reg      <= issue_next;
        rd_addr_reg    <= rd_addr_next;
        wr_left_reg    <= wr_left_next;
        start_reg      <= start_next;
        res_start_reg  <= res_start_next;
        res_status_reg <= res_status_next;
        out_start_reg  <= out_start_next;
        out_status_reg <= out_status_next;
    end

endmodule
